// File: hdl/pc2u_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pc2u_pkg
// Shared types for the code page to UTF-8 transcoder: byte sequence record
// and counter width.
// ----------------------------------------------------------------------------
package pc2u_pkg;

  localparam int unsigned SEQ_MAX = 3;   // longest UTF-8 sequence per source byte
  localparam int unsigned COUNT_W = 16;  // running output count

  typedef logic [7:0]         byte_t;
  typedef logic [1:0]         seq_len_t;  // 1 to SEQ_MAX
  typedef logic [1:0]         seq_idx_t;  // 0 to SEQ_MAX-1
  typedef logic [COUNT_W-1:0] count_t;

  // UTF-8 bytes for one source byte, bytes[0] goes out first
  typedef struct packed {
    byte_t [SEQ_MAX-1:0] bytes;
    seq_len_t            len;
  } utf8_seq_t;

endpackage : pc2u_pkg
`default_nettype wire

// File: hdl/pc2u_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pc2u_map
// Decodes one source byte into its one to three byte UTF-8 sequence.
// ----------------------------------------------------------------------------
module pc2u_map
  import pc2u_pkg::*;
(
  input  wire byte_t     src_byte,
  output utf8_seq_t      seq
);

  localparam byte_t ASCII_SPACE = 8'h20;
  localparam byte_t ASCII_DOT   = 8'h2E;
  localparam byte_t ASCII_COMMA = 8'h2C;
  localparam byte_t LEAD_E2     = 8'hE2;
  localparam byte_t LEAD_C2     = 8'hC2;
  localparam byte_t LEAD_C3     = 8'hC3;
  localparam byte_t LEAD_C5     = 8'hC5;
  localparam byte_t LEAD_C6     = 8'hC6;

  always_comb begin
    seq          = '0;
    seq.len      = 2'd1;
    seq.bytes[0] = src_byte;
    unique case (src_byte) inside
      8'h14, 8'h15, 8'h16, 8'h17, 8'h19: begin
        seq.bytes[0] = ASCII_SPACE;
      end
      8'h18, 8'h85: begin
        seq.bytes = {ASCII_DOT, ASCII_DOT, ASCII_DOT};
        seq.len   = 2'd3;
      end
      8'h80: begin
        seq.bytes = {8'hAC, 8'h82, LEAD_E2};
        seq.len   = 2'd3;
      end
      8'h81: begin
        seq.bytes[0] = ASCII_COMMA;
      end
      8'h83: begin
        seq.bytes = {8'h00, 8'h92, LEAD_C6};
        seq.len   = 2'd2;
      end
      8'h89: begin
        seq.bytes = {8'hB0, 8'h80, LEAD_E2};
        seq.len   = 2'd3;
      end
      8'h8A: begin
        seq.bytes = {8'h00, 8'hA0, LEAD_C5};
        seq.len   = 2'd2;
      end
      8'h8C: begin
        seq.bytes = {8'h00, 8'h92, LEAD_C5};
        seq.len   = 2'd2;
      end
      8'h95: begin
        seq.bytes = {8'h00, 8'hB7, LEAD_C2};
        seq.len   = 2'd2;
      end
      8'h97: begin
        seq.bytes = {8'h94, 8'h80, LEAD_E2};
        seq.len   = 2'd3;
      end
      8'h99: begin
        seq.bytes = {8'hA2, 8'h84, LEAD_E2};
        seq.len   = 2'd3;
      end
      8'h9C: begin
        seq.bytes = {8'h00, 8'h93, LEAD_C5};
        seq.len   = 2'd2;
      end
      default: begin
        if (src_byte[7:5] == 3'b100) begin
          // unmapped upper control range
          seq.bytes[0] = ASCII_SPACE;
        end else if (src_byte[7:6] == 2'b10) begin
          seq.bytes = {8'h00, src_byte, LEAD_C2};
          seq.len   = 2'd2;
        end else if (src_byte[7:6] == 2'b11) begin
          seq.bytes = {8'h00, src_byte, LEAD_C3};
          seq.len   = 2'd2;
        end
      end
    endcase
  end

endmodule : pc2u_map
`default_nettype wire

// File: hdl/pc2u_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pc2u_emit
// Result register: holds one decoded sequence and, while out_ready is high,
// sends it a byte per cycle; keeps the running count and the capacity check.
// ----------------------------------------------------------------------------
module pc2u_emit
  import pc2u_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             load,
  input  wire utf8_seq_t  seq,
  input  wire             last_of_text,
  input  wire count_t     max_count,
  output logic            take,
  output logic            out_valid,
  input  wire             out_ready,
  output byte_t           out_byte,
  output logic            out_byte_valid,
  output logic            out_last_of_run,
  output logic            out_end_of_text,
  output count_t          out_count_after
);

  logic      busy_r, busy_nxt;
  byte_t     bytes_r [SEQ_MAX];
  seq_len_t  len_r;
  seq_idx_t  idx_r, idx_nxt;
  count_t    base_r;
  logic      last_r;
  logic      drop_r;
  count_t    count_r, count_nxt;

  logic      drop;
  logic      final_byte;
  logic      advance;

  function automatic count_t sat_add(input count_t a, input logic [2:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + (COUNT_W+1)'(b);
    return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  endfunction

  assign drop       = (count_r >= max_count);
  assign final_byte = (idx_r == (len_r - 2'd1));
  assign advance    = busy_r && out_ready;
  assign take       = !busy_r || (advance && final_byte);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    if (advance) begin
      idx_nxt = idx_r + 2'd1;
      if (final_byte) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      if (last_of_text) begin
        count_nxt = '0;
      end else if (!drop) begin
        count_nxt = sat_add(count_r, {1'b0, seq.len});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  // payload: capture the sequence and the count it starts from
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < SEQ_MAX; i++) begin
        bytes_r[i] <= seq.bytes[i];
      end
      len_r  <= drop ? 2'd1 : seq.len;
      base_r <= count_r;
      last_r <= last_of_text;
      drop_r <= drop;
    end
  end

  assign out_valid       = busy_r;
  assign out_byte        = drop_r ? 8'h00 : bytes_r[idx_r];
  assign out_byte_valid  = !drop_r;
  assign out_last_of_run = final_byte;
  assign out_end_of_text = final_byte && last_r;
  assign out_count_after = drop_r ? base_r : sat_add(base_r, {1'b0, idx_r} + 3'd1);

endmodule : pc2u_emit
`default_nettype wire

// File: hdl/palm_charset_to_utf8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palm_charset_to_utf8
// Streams single-byte device code page text into UTF-8.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one source byte per word, with
//   in_last_of_text marking the final byte of a text.
// Output channel (out_valid/out_ready): one UTF-8 byte per word; each source
//   byte gives one to three words, the last flagged by out_last_of_run.
// cfg_wr_en/cfg_wr_data: write max_output_bytes; write it only while idle.
// Path: an accepted word is decoded from the input register into the result
//   register, which presents its first output word. Throughput: one output
//   word per cycle while out_ready is high; the result register's serializer
//   sets that rate. A new source byte is taken while the previous one drains.
// Capacity: when the running count is at or above max_output_bytes, the
//   byte is dropped and gives a single word with out_byte_valid low.
//   The count clears after the last byte of a text.
// Reset: synchronous, active low; clears the pipeline and the count and sets
//   max_output_bytes to 1996.
// Stall: with out_ready low the result holds, the input register fills and
//   in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module palm_charset_to_utf8
  import pc2u_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire [15:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [7:0]   in_src_byte,
  input  wire         in_last_of_text,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_run,
  output logic        out_end_of_text,
  output logic [15:0] out_count_after
);

  localparam count_t MAX_RESET = 16'd1996;

  count_t    max_r;
  logic      in_valid_r;
  byte_t     in_byte_r;
  logic      in_last_r;
  utf8_seq_t seq;
  logic      take;
  logic      load;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // input register: advance when empty or when its word moves on
  assign load     = in_valid_r && take;
  assign in_ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_src_byte;
      in_last_r <= in_last_of_text;
    end
  end

  // decode between input and result registers
  pc2u_map u_map (
    .src_byte (in_byte_r),
    .seq      (seq)
  );

  pc2u_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .seq             (seq),
    .last_of_text    (in_last_r),
    .max_count       (max_r),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_end_of_text (out_end_of_text),
    .out_count_after (out_count_after)
  );

`ifndef SYNTHESIS
  // a dropped byte is always a single zero word
  a_drop_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last_of_run && (out_byte == 8'h00))
    else $error("dropped byte not a single zero word");

  // an idle result register never blocks the input side
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register idle");

  // every emitted byte is counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_count_after != 16'd0)
    else $error("emitted byte with zero count");

  // end of text only on the final word of a byte
  a_eot_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_last_of_run)
    else $error("end of text before last word of run");
`endif

endmodule : palm_charset_to_utf8
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the code page to UTF-8 transcoder. A table of
// directed words covers every mapped code from 0x80 up, the range edges and
// the capacity drop, then random texts run under several capacity settings.
// Every output word is checked against a local model of the transcoder.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pc2u_pkg::*;

  localparam int IDLE_PCT    = 13;
  localparam int RAND_PHASES = 5;
  localparam int RAND_WORDS  = 60;      // source bytes per random phase
  localparam count_t CAP_MIN = 16'd4;
  localparam count_t CAP_MAX = 16'd65532;

  // Fixed UTF-8 bytes that the directed rows refer to
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_NUL   = 8'h00;

  // One output word as the transcoder presents it
  typedef struct packed {
    byte_t  data;
    logic   valid;
    logic   run_end;
    logic   text_end;
    count_t count;
  } out_word_t;

  // Directed table: either a source byte or a capacity write
  typedef enum logic [0:0] {
    ROW_WORD,
    ROW_CAP
  } row_kind_t;

  // For ROW_WORD rows with lit set, the first output word must show
  // lit_byte, lit_valid and num (its count). For ROW_CAP, num is the capacity.
  typedef struct packed {
    row_kind_t kind;
    byte_t     src;
    logic      last;
    logic      lit;
    byte_t     lit_byte;
    logic      lit_valid;
    count_t    num;
  } row_t;

  localparam int PLAN_LEN = 29;
  localparam row_t PLAN [0:PLAN_LEN-1] = '{
    // plain ASCII right after reset, range edges, control codes
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41,    1'b1, 16'd1},
    '{ROW_WORD, 8'h00, 1'b0, 1'b1, CH_NUL,   1'b1, 16'd2},
    '{ROW_WORD, 8'h7F, 1'b0, 1'b1, 8'h7F,    1'b1, 16'd3},
    '{ROW_WORD, 8'h14, 1'b0, 1'b1, CH_SPACE, 1'b1, 16'd4},
    '{ROW_WORD, 8'h18, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    // every fixed sequence in the 0x80-0x9F block, plus a plain one
    '{ROW_WORD, 8'h80, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h81, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h83, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h85, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h89, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h8A, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h8C, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h95, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h97, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h99, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h9C, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'h9F, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    // two-byte ranges at both ends, closing the text
    '{ROW_WORD, 8'hA0, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'hBF, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'hC0, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'hFF, 1'b1, 1'b0, CH_NUL,   1'b0, 16'd0},
    // smallest capacity: fill, overshoot with a 3-byte code, then drop
    '{ROW_CAP,  8'h00, 1'b0, 1'b0, CH_NUL,   1'b0, CAP_MIN},
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41,    1'b1, 16'd1},
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41,    1'b1, 16'd2},
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41,    1'b1, 16'd3},
    '{ROW_WORD, 8'h80, 1'b0, 1'b0, CH_NUL,   1'b0, 16'd0},
    '{ROW_WORD, 8'hC0, 1'b0, 1'b1, CH_NUL,   1'b0, 16'd6},
    // dropped last byte still ends the text and clears the count
    '{ROW_WORD, 8'h41, 1'b1, 1'b1, CH_NUL,   1'b0, 16'd6},
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41,    1'b1, 16'd1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_src_byte = '0;
  logic        in_last_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_of_run;
  logic        out_end_of_text;
  logic [15:0] out_count_after;

  // Model state: running count of the current text and the capacity
  count_t    text_count = '0;
  count_t    cap_bytes = 16'd1996;
  out_word_t utf8_due[$];
  int        idle_pct = IDLE_PCT;
  int        errors = 0;

  palm_charset_to_utf8 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_src_byte     (in_src_byte),
    .in_last_of_text (in_last_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_end_of_text (out_end_of_text),
    .out_count_after (out_count_after)
  );

  always #2 clk = ~clk;

  // UTF-8 bytes for one source byte; bytes[0] leaves first
  function automatic utf8_seq_t utf8_of(input byte_t c);
    utf8_seq_t s;
    s = '0;
    case (c)
      8'h14, 8'h15, 8'h16, 8'h17, 8'h19: begin
        s.bytes[0] = CH_SPACE; s.len = 2'd1;
      end
      8'h18, 8'h85: begin
        s.bytes[0] = 8'h2E; s.bytes[1] = 8'h2E; s.bytes[2] = 8'h2E; s.len = 2'd3;
      end
      8'h80: begin
        s.bytes[0] = 8'hE2; s.bytes[1] = 8'h82; s.bytes[2] = 8'hAC; s.len = 2'd3;
      end
      8'h81: begin
        s.bytes[0] = 8'h2C; s.len = 2'd1;
      end
      8'h83: begin
        s.bytes[0] = 8'hC6; s.bytes[1] = 8'h92; s.len = 2'd2;
      end
      8'h89: begin
        s.bytes[0] = 8'hE2; s.bytes[1] = 8'h80; s.bytes[2] = 8'hB0; s.len = 2'd3;
      end
      8'h8A: begin
        s.bytes[0] = 8'hC5; s.bytes[1] = 8'hA0; s.len = 2'd2;
      end
      8'h8C: begin
        s.bytes[0] = 8'hC5; s.bytes[1] = 8'h92; s.len = 2'd2;
      end
      8'h95: begin
        s.bytes[0] = 8'hC2; s.bytes[1] = 8'hB7; s.len = 2'd2;
      end
      8'h97: begin
        s.bytes[0] = 8'hE2; s.bytes[1] = 8'h80; s.bytes[2] = 8'h94; s.len = 2'd3;
      end
      8'h99: begin
        s.bytes[0] = 8'hE2; s.bytes[1] = 8'h84; s.bytes[2] = 8'hA2; s.len = 2'd3;
      end
      8'h9C: begin
        s.bytes[0] = 8'hC5; s.bytes[1] = 8'h93; s.len = 2'd2;
      end
      default: begin
        if (c >= 8'h80 && c < 8'hA0) begin
          s.bytes[0] = CH_SPACE; s.len = 2'd1;
        end else if (c >= 8'hA0 && c < 8'hC0) begin
          s.bytes[0] = 8'hC2; s.bytes[1] = c; s.len = 2'd2;
        end else if (c >= 8'hC0) begin
          s.bytes[0] = 8'hC3; s.bytes[1] = c; s.len = 2'd2;
        end else begin
          s.bytes[0] = c; s.len = 2'd1;
        end
      end
    endcase
    return s;
  endfunction

  // Advance the model by one accepted source byte and queue its output words.
  // A typed-in expectation replaces the first word's byte, flag and count.
  task automatic transcode_word(input byte_t src, input logic last, input row_t row);
    utf8_seq_t seq;
    out_word_t run [SEQ_MAX];
    out_word_t w;
    int        n;
    int        k;
    if (text_count >= cap_bytes) begin
      // at capacity: one empty word, count unchanged
      run[0] = '{CH_NUL, 1'b0, 1'b1, last, text_count};
      n = 1;
    end else begin
      seq = utf8_of(src);
      n = int'(seq.len);
      for (k = 0; k < n; k++) begin
        if (text_count != 16'hFFFF) text_count = text_count + 16'd1;
        run[k] = '{seq.bytes[k], 1'b1, k == n - 1, (k == n - 1) && last, text_count};
      end
    end
    if (last) text_count = '0;
    for (k = 0; k < n; k++) begin
      w = run[k];
      if (k == 0 && row.lit) begin
        w.data  = row.lit_byte;
        w.valid = row.lit_valid;
        w.count = row.num;
      end
      utf8_due.push_back(w);
    end
  endtask

  // Drive one source byte; entered and left at a falling edge
  task automatic put_word(input row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_src_byte     = row.src;
    in_last_of_text = row.last;
    do @(posedge clk); while (!in_ready);
    transcode_word(row.src, row.last, row);
    @(negedge clk);
  endtask

  // Write the capacity once the transcoder has drained
  task automatic set_capacity(input count_t cap);
    in_valid = 1'b0;
    while (utf8_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cap_bytes = cap;
  endtask

  // Lean the random bytes toward the mapped codes, keep full-range noise too
  function automatic byte_t pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return byte_t'($urandom_range(8'h19, 8'h14));
    if (r < 45) return byte_t'($urandom_range(8'h9F, 8'h80));
    if (r < 65) return byte_t'($urandom_range(8'hFF, 8'hA0));
    return byte_t'($urandom_range(255));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Stall the output side at random; ready changes only on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin : watch_out
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got byte %0h valid %0b count %0d",
                 $time, out_byte, out_byte_valid, out_count_after);
      end else begin
        want = utf8_due.pop_front();
        check_field("out_byte",        want.data,     out_byte);
        check_field("out_byte_valid",  want.valid,    out_byte_valid);
        check_field("out_last_of_run", want.run_end,  out_last_of_run);
        check_field("out_end_of_text", want.text_end, out_end_of_text);
        check_field("out_count_after", want.count,    out_count_after);
      end
    end
  end

  initial begin : stimulus
    row_t   row;
    count_t cap;
    int     k;
    int     phase;
    int     left;
    int     len;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].kind == ROW_CAP) set_capacity(PLAN[k].num);
      else put_word(PLAN[k]);
    end

    // random texts; the middle phase runs with no idling on either side
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       cap = CAP_MAX;
        1:       cap = CAP_MIN;
        2:       cap = count_t'($urandom_range(40, 4));
        3:       cap = count_t'($urandom_range(65532, 4));
        default: cap = count_t'($urandom_range(12, 5));
      endcase
      set_capacity(cap);
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      left = RAND_WORDS;
      while (left > 0) begin
        len = $urandom_range(24, 1);
        if (len > left) len = left;
        for (k = 0; k < len; k++) begin
          row = '0;
          row.kind = ROW_WORD;
          row.src  = pick_char();
          row.last = (k == len - 1);
          put_word(row);
        end
        left -= len;
      end
    end
    idle_pct = IDLE_PCT;
    in_valid = 1'b0;

    // drain, then give stray words a chance to show up
    while (utf8_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule : tb_top

// File: sim.f
hdl/pc2u_pkg.sv
hdl/pc2u_map.sv
hdl/pc2u_emit.sv
hdl/palm_charset_to_utf8.sv
test/tb_top.sv
